// ===== src/rbl_pkg.sv =====
package rbl_pkg;

  localparam int ADDR_W     = 40;
  localparam int ROW_W      = 24;
  localparam int LAT_W      = 33;
  localparam int DATA_W     = 32;
  localparam int PADDR_W    = 5;
  localparam int CH_OUT_W   = 2;
  localparam int RK_OUT_W   = 1;
  localparam int BK_OUT_W   = 3;
  localparam int FLAT_OUT_W = 6;
  localparam int DSR_W      = 24;
  localparam int DIV_STEPS  = ADDR_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam int DEF_MAX_CHANNELS = 4;
  localparam int DEF_MAX_RANKS    = 2;
  localparam int DEF_MAX_BANKS    = 8;

  localparam logic [ROW_W-1:0] NO_ROW = '1;

  localparam logic [16:0] RST_ROW_BYTES     = 17'd2048;
  localparam logic [2:0]  RST_CHANNEL_COUNT = 3'd1;
  localparam logic [1:0]  RST_RANK_COUNT    = 2'd1;
  localparam logic [3:0]  RST_BANK_COUNT    = 4'd8;
  localparam logic [23:0] RST_ROW_COUNT     = 24'd32768;
  localparam logic [31:0] RST_LATENCY       = 32'd0;

  typedef enum logic [2:0] {
    REG_ROW_BYTES     = 3'd0,
    REG_CHANNEL_COUNT = 3'd1,
    REG_RANK_COUNT    = 3'd2,
    REG_BANK_COUNT    = 3'd3,
    REG_ROW_COUNT     = 3'd4,
    REG_HIT_LATENCY   = 3'd5,
    REG_READ_MISS     = 3'd6,
    REG_WRITE_MISS    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [16:0] row_bytes;
    logic [2:0]  channel_count;
    logic [1:0]  rank_count;
    logic [3:0]  bank_count;
    logic [23:0] row_count;
    logic [31:0] hit_latency;
    logic [31:0] read_miss_extra;
    logic [31:0] write_miss_extra;
  } cfg_t;

  typedef struct packed {
    logic run;
    logic done;
  } div_stat_t;

endpackage

// ===== src/rbl_ram.sv =====
module rbl_ram #(
  parameter int WIDTH = rbl_pkg::ROW_W,
  parameter int DEPTH = rbl_pkg::DEF_MAX_CHANNELS * rbl_pkg::DEF_MAX_RANKS
                        * rbl_pkg::DEF_MAX_BANKS,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/rbl_div.sv =====
module rbl_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rbl_pkg::ADDR_W-1:0] dividend,
  input  logic [rbl_pkg::DSR_W-1:0]  divisor,
  output logic [rbl_pkg::ADDR_W-1:0] quotient,
  output logic [rbl_pkg::DSR_W-1:0]  remainder,
  output rbl_pkg::div_stat_t         stat
);

  localparam int AW = rbl_pkg::ADDR_W;
  localparam int DW = rbl_pkg::DSR_W;

  logic [AW-1:0] a;
  logic [DW-1:0] r;
  logic [DW-1:0] d;
  logic [rbl_pkg::DIV_CNT_W-1:0] cnt;
  logic run;
  logic done;

  logic [DW:0]   t1, t2;
  logic          ge1, ge2;
  logic [DW-1:0] r1, r_next;
  logic [AW-1:0] a1, a_next;

  // two restoring steps per cycle
  always_comb begin
    t1     = {r, a[AW-1]};
    ge1    = t1 >= {1'b0, d};
    r1     = ge1 ? DW'(t1 - {1'b0, d}) : t1[DW-1:0];
    a1     = {a[AW-2:0], ge1};
    t2     = {r1, a1[AW-1]};
    ge2    = t2 >= {1'b0, d};
    r_next = ge2 ? DW'(t2 - {1'b0, d}) : t2[DW-1:0];
    a_next = {a1[AW-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (divisor == DW'(1)) begin
          done <= 1'b1;
        end else begin
          run <= 1'b1;
        end
      end else if (run && cnt == rbl_pkg::DIV_CNT_W'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a   <= dividend;
      r   <= '0;
      d   <= divisor;
      cnt <= rbl_pkg::DIV_CNT_W'(rbl_pkg::DIV_STEPS);
    end else if (run) begin
      a   <= a_next;
      r   <= r_next;
      cnt <= cnt - rbl_pkg::DIV_CNT_W'(1);
    end
  end

  assign quotient  = a;
  assign remainder = r;
  assign stat.run  = run;
  assign stat.done = done;

endmodule

// ===== src/rbl_cfg.sv =====
module rbl_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbl_pkg::PADDR_W-1:0] paddr,
  input  logic [rbl_pkg::DATA_W-1:0]  pwdata,
  output logic [rbl_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output rbl_pkg::cfg_t               cfg
);

  rbl_pkg::reg_idx_t idx;
  logic wr;

  assign idx    = rbl_pkg::reg_idx_t'(paddr[rbl_pkg::PADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_bytes        <= rbl_pkg::RST_ROW_BYTES;
      cfg.channel_count    <= rbl_pkg::RST_CHANNEL_COUNT;
      cfg.rank_count       <= rbl_pkg::RST_RANK_COUNT;
      cfg.bank_count       <= rbl_pkg::RST_BANK_COUNT;
      cfg.row_count        <= rbl_pkg::RST_ROW_COUNT;
      cfg.hit_latency      <= rbl_pkg::RST_LATENCY;
      cfg.read_miss_extra  <= rbl_pkg::RST_LATENCY;
      cfg.write_miss_extra <= rbl_pkg::RST_LATENCY;
    end else if (wr) begin
      case (idx)
        rbl_pkg::REG_ROW_BYTES:     cfg.row_bytes        <= pwdata[16:0];
        rbl_pkg::REG_CHANNEL_COUNT: cfg.channel_count    <= pwdata[2:0];
        rbl_pkg::REG_RANK_COUNT:    cfg.rank_count       <= pwdata[1:0];
        rbl_pkg::REG_BANK_COUNT:    cfg.bank_count       <= pwdata[3:0];
        rbl_pkg::REG_ROW_COUNT:     cfg.row_count        <= pwdata[23:0];
        rbl_pkg::REG_HIT_LATENCY:   cfg.hit_latency      <= pwdata;
        rbl_pkg::REG_READ_MISS:     cfg.read_miss_extra  <= pwdata;
        rbl_pkg::REG_WRITE_MISS:    cfg.write_miss_extra <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      rbl_pkg::REG_ROW_BYTES:     prdata[16:0] = cfg.row_bytes;
      rbl_pkg::REG_CHANNEL_COUNT: prdata[2:0]  = cfg.channel_count;
      rbl_pkg::REG_RANK_COUNT:    prdata[1:0]  = cfg.rank_count;
      rbl_pkg::REG_BANK_COUNT:    prdata[3:0]  = cfg.bank_count;
      rbl_pkg::REG_ROW_COUNT:     prdata[23:0] = cfg.row_count;
      rbl_pkg::REG_HIT_LATENCY:   prdata       = cfg.hit_latency;
      rbl_pkg::REG_READ_MISS:     prdata       = cfg.read_miss_extra;
      rbl_pkg::REG_WRITE_MISS:    prdata       = cfg.write_miss_extra;
      default:                    prdata       = '0;
    endcase
  end

endmodule

// ===== src/dram_row_buffer_latency_model.sv =====
// Open-page row buffer model for DRAM accesses. Pulse start while busy is low to hand in one
// item (address, command). The address is split by five divisions on one shared divider that
// retires two quotient bits per cycle; a division by one finishes without running its steps.
// After the divisions the flat bank index is formed and the open-row table is read, compared
// and updated on a miss. The result appears on the result ports, marked by done, which is high
// for a single cycle; it cannot be held off and must be taken in that cycle. busy drops in the
// done cycle, so the next item can go in right then. After reset the open-row table is swept
// to the empty mark, one entry per cycle, over all MAX_CHANNELS*MAX_RANKS*MAX_BANKS entries
// (64 by default) with busy high; register writes are taken meanwhile. Write the registers
// only while busy is low.
module dram_row_buffer_latency_model_top #(
  parameter int MAX_CHANNELS = rbl_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_RANKS    = rbl_pkg::DEF_MAX_RANKS,
  parameter int MAX_BANKS    = rbl_pkg::DEF_MAX_BANKS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [rbl_pkg::ADDR_W-1:0]      address,
  input  logic                            command,
  output logic                            done,
  output logic [rbl_pkg::CH_OUT_W-1:0]    channel_sel,
  output logic [rbl_pkg::RK_OUT_W-1:0]    rank_sel,
  output logic [rbl_pkg::BK_OUT_W-1:0]    bank_sel,
  output logic [rbl_pkg::ROW_W-1:0]       row_sel,
  output logic [rbl_pkg::FLAT_OUT_W-1:0]  flat_bank,
  output logic                            row_hit,
  output logic [rbl_pkg::LAT_W-1:0]       latency,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rbl_pkg::PADDR_W-1:0]     paddr,
  input  logic [rbl_pkg::DATA_W-1:0]      pwdata,
  output logic [rbl_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);

  localparam int DEPTH = MAX_CHANNELS * MAX_RANKS * MAX_BANKS;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int RK_W  = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
  localparam int BK_W  = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
  localparam int DW    = rbl_pkg::DSR_W;
  localparam int RW    = rbl_pkg::ROW_W;
  localparam int LW    = rbl_pkg::LAT_W;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_ISSUE = 7'b0000100,
    S_WAIT  = 7'b0001000,
    S_FLAT  = 7'b0010000,
    S_READ  = 7'b0100000,
    S_CMP   = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    OP_COLUMN  = 3'd0,
    OP_CHANNEL = 3'd1,
    OP_BANK    = 3'd2,
    OP_RANK    = 3'd3,
    OP_ROW     = 3'd4
  } div_op_t;

  state_t  state, state_next;
  div_op_t op, op_next;

  rbl_pkg::cfg_t      cfg;
  rbl_pkg::div_stat_t div_stat;

  logic [rbl_pkg::ADDR_W-1:0] a_r;
  logic [rbl_pkg::ADDR_W-1:0] quo;
  logic [DW-1:0]              rem;
  logic [DW-1:0]              divisor;
  logic                       cmd_r;
  logic [CH_W-1:0]            ch_r;
  logic [RK_W-1:0]            rk_r;
  logic [BK_W-1:0]            bk_r;
  logic [RW-1:0]              rw_r;
  logic [IDX_W-1:0]           flat_r;
  logic [IDX_W-1:0]           flat_calc;
  logic [IDX_W-1:0]           clr_idx;

  logic [DW-1:0] cols_eff, chs_eff, rks_eff, bks_eff, rws_eff;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [RW-1:0]     ram_wdata;
  logic [RW-1:0]     ram_rdata;
  logic              hit;
  logic [LW-1:0]     lat_calc;

  logic [CH_W+rbl_pkg::CH_OUT_W-1:0]     ch_wide;
  logic [RK_W+rbl_pkg::RK_OUT_W-1:0]     rk_wide;
  logic [BK_W+rbl_pkg::BK_OUT_W-1:0]     bk_wide;
  logic [IDX_W+rbl_pkg::FLAT_OUT_W-1:0]  flat_wide;

  rbl_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // effective sizes: zero acts as one, channel, rank and bank counts capped at the maxima
  always_comb begin
    cols_eff = (cfg.row_bytes == '0) ? DW'(1) : DW'(cfg.row_bytes);
    rws_eff  = (cfg.row_count == '0) ? DW'(1) : cfg.row_count;
    if (cfg.channel_count == '0) begin
      chs_eff = DW'(1);
    end else if (32'(cfg.channel_count) > 32'(MAX_CHANNELS)) begin
      chs_eff = DW'(MAX_CHANNELS);
    end else begin
      chs_eff = DW'(cfg.channel_count);
    end
    if (cfg.rank_count == '0) begin
      rks_eff = DW'(1);
    end else if (32'(cfg.rank_count) > 32'(MAX_RANKS)) begin
      rks_eff = DW'(MAX_RANKS);
    end else begin
      rks_eff = DW'(cfg.rank_count);
    end
    if (cfg.bank_count == '0) begin
      bks_eff = DW'(1);
    end else if (32'(cfg.bank_count) > 32'(MAX_BANKS)) begin
      bks_eff = DW'(MAX_BANKS);
    end else begin
      bks_eff = DW'(cfg.bank_count);
    end
  end

  always_comb begin
    case (op)
      OP_COLUMN:  divisor = cols_eff;
      OP_CHANNEL: divisor = chs_eff;
      OP_BANK:    divisor = bks_eff;
      OP_RANK:    divisor = rks_eff;
      OP_ROW:     divisor = rws_eff;
      default:    divisor = rws_eff;
    endcase
  end

  rbl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (state == S_ISSUE),
    .dividend  (a_r),
    .divisor   (divisor),
    .quotient  (quo),
    .remainder (rem),
    .stat      (div_stat)
  );

  // flat index stays below the table depth, so modular arithmetic is exact
  assign flat_calc = (IDX_W'(ch_r) * IDX_W'(rks_eff) + IDX_W'(rk_r)) * IDX_W'(bks_eff)
                     + IDX_W'(bk_r);

  assign hit      = (ram_rdata == rw_r);
  assign lat_calc = LW'(cfg.hit_latency)
                    + (hit ? LW'(0)
                           : (cmd_r ? LW'(cfg.write_miss_extra) : LW'(cfg.read_miss_extra)));

  assign ram_we    = (state == S_CLEAR) || ((state == S_CMP) && !hit);
  assign ram_waddr = (state == S_CLEAR) ? clr_idx : flat_r;
  assign ram_wdata = (state == S_CLEAR) ? rbl_pkg::NO_ROW : rw_r;

  rbl_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_open_row (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (flat_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    op_next    = op;
    case (state)
      S_CLEAR: begin
        if (clr_idx == IDX_W'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_ISSUE;
          op_next    = OP_COLUMN;
        end
      end
      S_ISSUE: state_next = S_WAIT;
      S_WAIT: begin
        if (div_stat.done) begin
          case (op)
            OP_COLUMN:  begin op_next = OP_CHANNEL; state_next = S_ISSUE; end
            OP_CHANNEL: begin op_next = OP_BANK;    state_next = S_ISSUE; end
            OP_BANK:    begin op_next = OP_RANK;    state_next = S_ISSUE; end
            OP_RANK:    begin op_next = OP_ROW;     state_next = S_ISSUE; end
            OP_ROW:     state_next = S_FLAT;
            default:    state_next = S_FLAT;
          endcase
        end
      end
      S_FLAT:  state_next = S_READ;
      S_READ:  state_next = S_CMP;
      S_CMP:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      op      <= OP_COLUMN;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      done  <= (state == S_CMP);
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
    end
  end

  assign ch_wide   = {{rbl_pkg::CH_OUT_W{1'b0}}, ch_r};
  assign rk_wide   = {{rbl_pkg::RK_OUT_W{1'b0}}, rk_r};
  assign bk_wide   = {{rbl_pkg::BK_OUT_W{1'b0}}, bk_r};
  assign flat_wide = {{rbl_pkg::FLAT_OUT_W{1'b0}}, flat_r};

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      a_r   <= address;
      cmd_r <= command;
    end
    if (state == S_WAIT && div_stat.done) begin
      case (op)
        OP_COLUMN:  a_r <= quo;
        OP_CHANNEL: begin ch_r <= rem[CH_W-1:0]; a_r <= quo; end
        OP_BANK:    begin bk_r <= rem[BK_W-1:0]; a_r <= quo; end
        OP_RANK:    begin rk_r <= rem[RK_W-1:0]; a_r <= quo; end
        OP_ROW:     rw_r <= rem;
        default: ;
      endcase
    end
    if (state == S_FLAT) begin
      flat_r <= flat_calc;
    end
    if (state == S_CMP) begin
      channel_sel <= ch_wide[rbl_pkg::CH_OUT_W-1:0];
      rank_sel    <= rk_wide[rbl_pkg::RK_OUT_W-1:0];
      bank_sel    <= bk_wide[rbl_pkg::BK_OUT_W-1:0];
      row_sel     <= rw_r;
      flat_bank   <= flat_wide[rbl_pkg::FLAT_OUT_W-1:0];
      row_hit     <= hit;
      latency     <= lat_calc;
    end
  end

  assign busy = (state != S_IDLE);

`ifndef SYNTHESIS
  a_done_after_cmp: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_CMP))
    else $error("result strobe without a table compare");

  a_cmp_then_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |=> (done && !busy))
    else $error("compare not followed by result and ready");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_CLEAR) |-> !div_stat.run)
    else $error("divider running while sequencer is not waiting on it");
`endif

endmodule

// ===== dv/rbl_access_checker.sv =====
module rbl_access_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic [rbl_pkg::ADDR_W-1:0]       address,
  input  logic                             command,
  input  logic                             done,
  input  logic [rbl_pkg::CH_OUT_W-1:0]     channel_sel,
  input  logic [rbl_pkg::RK_OUT_W-1:0]     rank_sel,
  input  logic [rbl_pkg::BK_OUT_W-1:0]     bank_sel,
  input  logic [rbl_pkg::ROW_W-1:0]        row_sel,
  input  logic [rbl_pkg::FLAT_OUT_W-1:0]   flat_bank,
  input  logic                             row_hit,
  input  logic [rbl_pkg::LAT_W-1:0]        latency,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [rbl_pkg::PADDR_W-1:0]      paddr,
  input  logic [rbl_pkg::DATA_W-1:0]       pwdata,
  output int                               fail_count,
  output int                               pending
);
  import rbl_pkg::*;

  localparam int BANK_SLOTS = DEF_MAX_CHANNELS * DEF_MAX_RANKS * DEF_MAX_BANKS;

  typedef struct packed {
    logic [CH_OUT_W-1:0]   chan;
    logic [RK_OUT_W-1:0]   rank;
    logic [BK_OUT_W-1:0]   bank;
    logic [ROW_W-1:0]      row;
    logic [FLAT_OUT_W-1:0] flat;
    logic                  hit;
    logic [LAT_W-1:0]      lat;
  } access_result_t;

  cfg_t             cfg;
  logic [ROW_W-1:0] open_rows [BANK_SLOTS];
  access_result_t   due_results [$];

  function automatic longint unsigned clamp_size(longint unsigned v, longint unsigned cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  // decodes one access and updates the open-row table
  function automatic access_result_t decode_access(logic [ADDR_W-1:0] addr, logic wr);
    longint unsigned a, chs, rks, bks, rws, ch, rk, bk, rw, flat;
    access_result_t r;
    chs = clamp_size(cfg.channel_count, DEF_MAX_CHANNELS);
    rks = clamp_size(cfg.rank_count, DEF_MAX_RANKS);
    bks = clamp_size(cfg.bank_count, DEF_MAX_BANKS);
    rws = clamp_size(cfg.row_count, 24'hFFFFFF);
    a = addr;
    a = a / clamp_size(cfg.row_bytes, 17'h1FFFF);
    ch = a % chs;
    a = a / chs;
    bk = a % bks;
    a = a / bks;
    rk = a % rks;
    a = a / rks;
    rw = a % rws;
    flat = (ch * rks + rk) * bks + bk;
    if (flat >= BANK_SLOTS) flat = BANK_SLOTS - 1;
    r.chan = CH_OUT_W'(ch);
    r.rank = RK_OUT_W'(rk);
    r.bank = BK_OUT_W'(bk);
    r.row  = ROW_W'(rw);
    r.flat = FLAT_OUT_W'(flat);
    r.hit  = (open_rows[flat] == ROW_W'(rw));
    r.lat  = LAT_W'(cfg.hit_latency);
    if (!r.hit) begin
      open_rows[flat] = ROW_W'(rw);
      r.lat = r.lat + (wr ? cfg.write_miss_extra : cfg.read_miss_extra);
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    access_result_t want;
    if (rst) begin
      cfg.row_bytes        = RST_ROW_BYTES;
      cfg.channel_count    = RST_CHANNEL_COUNT;
      cfg.rank_count       = RST_RANK_COUNT;
      cfg.bank_count       = RST_BANK_COUNT;
      cfg.row_count        = RST_ROW_COUNT;
      cfg.hit_latency      = RST_LATENCY;
      cfg.read_miss_extra  = RST_LATENCY;
      cfg.write_miss_extra = RST_LATENCY;
      foreach (open_rows[i]) open_rows[i] = NO_ROW;
      due_results.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (done) begin
        if (due_results.size() == 0) begin
          $error("result with no item outstanding");
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("channel_sel", want.chan, channel_sel);
          check_field("rank_sel", want.rank, rank_sel);
          check_field("bank_sel", want.bank, bank_sel);
          check_field("row_sel", want.row, row_sel);
          check_field("flat_bank", want.flat, flat_bank);
          check_field("row_hit", want.hit, row_hit);
          check_field("latency", want.lat, latency);
        end
      end
      if (start && !busy) begin
        due_results.insert(due_results.size(), decode_access(address, command));
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_ROW_BYTES:     cfg.row_bytes        = pwdata[16:0];
          REG_CHANNEL_COUNT: cfg.channel_count    = pwdata[2:0];
          REG_RANK_COUNT:    cfg.rank_count       = pwdata[1:0];
          REG_BANK_COUNT:    cfg.bank_count       = pwdata[3:0];
          REG_ROW_COUNT:     cfg.row_count        = pwdata[23:0];
          REG_HIT_LATENCY:   cfg.hit_latency      = pwdata;
          REG_READ_MISS:     cfg.read_miss_extra  = pwdata;
          REG_WRITE_MISS:    cfg.write_miss_extra = pwdata;
          default: ;
        endcase
      end
      pending = due_results.size();
    end
  end

endmodule

// ===== dv/dram_row_buffer_latency_model_top_test.sv =====
module dram_row_buffer_latency_model_top_test;
  import rbl_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 240;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [ADDR_W-1:0]     address;
  logic                  command;
  logic                  done;
  logic [CH_OUT_W-1:0]   channel_sel;
  logic [RK_OUT_W-1:0]   rank_sel;
  logic [BK_OUT_W-1:0]   bank_sel;
  logic [ROW_W-1:0]      row_sel;
  logic [FLAT_OUT_W-1:0] flat_bank;
  logic                  row_hit;
  logic [LAT_W-1:0]      latency;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]     pwdata;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int quiet_cycles = 0;
  int idle_pct;
  int idle_plan [6] = '{0, 74, 8, 74, 0, 8};

  // effective geometry as last written
  longint unsigned cols, chs, rks, bks, rws;
  int unsigned     row_pool [3];

  always #1 clk = ~clk;

  dram_row_buffer_latency_model_top u_dut (.*);

  rbl_access_checker u_checker (.*);

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pwrite)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[dram_row_buffer_latency_model_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic longint unsigned eff_size(longint unsigned v, longint unsigned cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic logic [ADDR_W-1:0] compose_addr(longint unsigned row, longint unsigned ch,
                                                     longint unsigned rk, longint unsigned bk,
                                                     longint unsigned col);
    return ADDR_W'(((((row * rks + rk) * bks + bk) * chs + ch) * cols) + col);
  endfunction

  task automatic cfg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_config(logic [16:0] rb, logic [2:0] cc, logic [1:0] rc, logic [3:0] bc,
                              logic [23:0] rwc, logic [31:0] hl, logic [31:0] rme,
                              logic [31:0] wme);
    cfg_write(REG_ROW_BYTES, rb);
    cfg_write(REG_CHANNEL_COUNT, cc);
    cfg_write(REG_RANK_COUNT, rc);
    cfg_write(REG_BANK_COUNT, bc);
    cfg_write(REG_ROW_COUNT, rwc);
    cfg_write(REG_HIT_LATENCY, hl);
    cfg_write(REG_READ_MISS, rme);
    cfg_write(REG_WRITE_MISS, wme);
    cols = eff_size(rb, 17'h1FFFF);
    chs  = eff_size(cc, DEF_MAX_CHANNELS);
    rks  = eff_size(rc, DEF_MAX_RANKS);
    bks  = eff_size(bc, DEF_MAX_BANKS);
    rws  = eff_size(rwc, 24'hFFFFFF);
    foreach (row_pool[i]) row_pool[i] = $urandom_range(32'(rws - 1));
  endtask

  function automatic logic [31:0] pick_latency();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_config();
    logic [16:0] rb;
    logic [23:0] rwc;
    case ($urandom_range(3))
      0:       rb = 17'($urandom_range(64, 1));
      1:       rb = 17'($urandom_range(65536, 1));
      2:       rb = 17'(1 << $urandom_range(16));
      default: rb = 17'($urandom_range(17'h1FFFF));
    endcase
    case ($urandom_range(2))
      0:       rwc = 24'($urandom_range(4));
      1:       rwc = 24'($urandom_range(1024, 1));
      default: rwc = 24'($urandom);
    endcase
    apply_config(rb, 3'($urandom_range(7)), 2'($urandom_range(3)), 4'($urandom_range(15)),
                 rwc, pick_latency(), pick_latency(), pick_latency());
  endtask

  task automatic send_item(logic [ADDR_W-1:0] a, logic wr);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    address <= a;
    command <= wr;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // mostly accesses that revisit a few rows per bank, some fresh rows, some raw noise
  task automatic random_item();
    longint unsigned  row;
    logic [ADDR_W-1:0] a;
    int unsigned      pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      row = row_pool[$urandom_range(2)];
    end else begin
      row = $urandom_range(32'(rws - 1)) + rws * $urandom_range(3);
    end
    if (pick < 85) begin
      a = compose_addr(row, $urandom_range(32'(chs - 1)), $urandom_range(32'(rks - 1)),
                       $urandom_range(32'(bks - 1)), $urandom_range(32'(cols - 1)));
    end else begin
      a = ADDR_W'({$urandom, $urandom});
    end
    send_item(a, 1'($urandom_range(1)));
  endtask

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    address  = '0;
    command  = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    idle_pct = 0;
    cols     = 2048;
    chs      = 1;
    rks      = 1;
    bks      = 8;
    rws      = 32768;
    foreach (row_pool[i]) row_pool[i] = $urandom_range(32'(rws - 1));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset geometry
    send_item('0, 1'b0);
    send_item('0, 1'b1);
    send_item('1, 1'b0);
    send_item(40'd2048, 1'b1);
    send_item(40'd16384, 1'b0);
    drain();
    // zero sizes, table kept across the change
    apply_config('0, '0, '0, '0, '0, '1, '1, 32'd1);
    send_item(40'h12_3456_789A, 1'b0);
    send_item('1, 1'b1);
    drain();
    // latency sum carries into the top latency bit
    apply_config('0, '0, '0, '0, 24'd2, '1, '1, 32'd1);
    send_item(40'd1, 1'b0);
    send_item(40'd2, 1'b1);
    drain();
    // oversized counts
    apply_config(17'd1, 3'd7, 2'd3, 4'd15, 24'hFFFFFF, '0, '1, '1);
    send_item(40'd63, 1'b0);
    send_item(40'd63, 1'b1);
    send_item(40'd383, 1'b1);
    send_item('1, 1'b0);
    send_item(40'h55_5555_5555, 1'b1);
    drain();
    apply_config(17'h1FFFF, 3'd4, 2'd2, 4'd8, 24'd1, 32'd5, 32'd7, 32'd11);
    send_item('1, 1'b0);
    send_item(40'h1FFFF, 1'b1);
    send_item(40'hAA_AAAA_AAAA, 1'b0);

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0:       apply_config('1, 3'd7, 2'd3, 4'd15, '1, '1, '1, '1);
        1:       apply_config('0, '0, '0, '0, '0, '0, '0, '0);
        default: random_config();
      endcase
      idle_pct = idle_plan[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == PHASE_ITEMS / 2) drain();
        random_item();
      end
    end

    drain();
    repeat (150) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[dram_row_buffer_latency_model_top] OK");
    end else begin
      $display("[dram_row_buffer_latency_model_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rbl_pkg.sv
src/rbl_ram.sv
src/rbl_div.sv
src/rbl_cfg.sv
src/dram_row_buffer_latency_model.sv
dv/rbl_access_checker.sv
dv/dram_row_buffer_latency_model_top_test.sv
